// File: rtl/ghalloc_pkg.sv
// ---------------------------------------------------------------------------
// ghalloc_pkg - shared types and constants of the generational handle allocator
// Slot count, derived widths, request and status codes, beat structs and the
// control struct between the sequencer and the slot store.
// ---------------------------------------------------------------------------
package ghalloc_pkg;

    localparam int SLOTS = 64;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int GEN_W = 32;
    localparam int OUT_IDX_W = 12;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_FREE   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_INVALID  = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] slot_index;
        logic [31:0] handle_generation;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_IDX_W-1:0] out_index;
        logic [GEN_W-1:0]     out_generation;
    } t_out_beat;

    // accesses issued by the sequencer to the slot store
    typedef struct packed {
        logic             gen_re;
        logic [IDX_W-1:0] gen_raddr;
        logic             gen_we;
        logic [IDX_W-1:0] gen_waddr;
        logic [GEN_W-1:0] gen_wdata;
        logic             stk_re;
        logic [IDX_W-1:0] stk_raddr;
        logic             stk_we;
        logic [IDX_W-1:0] stk_waddr;
        logic [IDX_W-1:0] stk_wdata;
    } t_mem_req;

endpackage

// File: rtl/ghalloc_store.sv
// ---------------------------------------------------------------------------
// ghalloc_store - generation table and free stack
// Two single-port-read, single-port-write memories with registered reads.
// Per-entry valid bits stand in for the reset contents.
// ---------------------------------------------------------------------------
module ghalloc_store (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ghalloc_pkg::t_mem_req                   i_req,
    output logic [ghalloc_pkg::GEN_W-1:0]           o_gen_rdata,
    output logic [ghalloc_pkg::IDX_W-1:0]           o_stk_rdata
);

    logic [ghalloc_pkg::GEN_W-1:0] r_gen_mem [ghalloc_pkg::SLOTS];
    logic [ghalloc_pkg::IDX_W-1:0] r_stk_mem [ghalloc_pkg::SLOTS];
    logic [ghalloc_pkg::SLOTS-1:0] r_gen_vld;
    logic [ghalloc_pkg::SLOTS-1:0] r_stk_vld;

    logic [ghalloc_pkg::GEN_W-1:0] r_gen_rd;
    logic                          r_gen_rd_vld;
    logic [ghalloc_pkg::IDX_W-1:0] r_stk_rd;
    logic [ghalloc_pkg::IDX_W-1:0] r_stk_rd_dflt;
    logic                          r_stk_rd_vld;

    // memory arrays, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.gen_we) begin
            r_gen_mem[i_req.gen_waddr] <= i_req.gen_wdata;
        end
        if (i_req.stk_we) begin
            r_stk_mem[i_req.stk_waddr] <= i_req.stk_wdata;
        end
        if (i_req.gen_re) begin
            r_gen_rd     <= r_gen_mem[i_req.gen_raddr];
            r_gen_rd_vld <= r_gen_vld[i_req.gen_raddr];
        end
        if (i_req.stk_re) begin
            r_stk_rd      <= r_stk_mem[i_req.stk_raddr];
            r_stk_rd_vld  <= r_stk_vld[i_req.stk_raddr];
            // reset order: entry k holds SLOTS-1-k
            r_stk_rd_dflt <= ghalloc_pkg::IDX_W'(ghalloc_pkg::SLOTS - 1) - i_req.stk_raddr;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_vld <= '0;
            r_stk_vld <= '0;
        end else begin
            if (i_req.gen_we) begin
                r_gen_vld[i_req.gen_waddr] <= 1'b1;
            end
            if (i_req.stk_we) begin
                r_stk_vld[i_req.stk_waddr] <= 1'b1;
            end
        end
    end

    assign o_gen_rdata = r_gen_rd_vld ? r_gen_rd : ghalloc_pkg::GEN_W'(1);
    assign o_stk_rdata = r_stk_rd_vld ? r_stk_rd : r_stk_rd_dflt;

endmodule

// File: rtl/generational_handle_allocator_top.sv
// ---------------------------------------------------------------------------
// generational_handle_allocator_top - generational slot handle allocator
// Hands out (slot, generation) handles from a free stack, checks handles and
// retires slots by bumping their generation.
// ---------------------------------------------------------------------------
// One request beat in, one result beat out. Requests are served one at a
// time: allocate reads the stack, then the popped slot's generation, then
// updates (from an empty stack, it updates at once); look up and free read
// the generation, then update, free also writing back. A further request
// is taken in the cycle after the update. The steps follow the registered
// reads of the two slot memories. The result sits in an output register, so
// the next request is accepted while an earlier result waits to be taken.
// After reset every generation is 1 and allocations return slots 0, 1, 2 and
// so on; no clearing pass is needed, the block is ready at once.
module generational_handle_allocator_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ghalloc_pkg::t_in_beat  i_in_beat,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ghalloc_pkg::t_out_beat o_out_beat
);

    // one-hot sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    ghalloc_pkg::t_in_beat         r_req;                 // captured request
    logic [ghalloc_pkg::IDX_W-1:0] r_slot, n_slot;        // popped slot
    logic [ghalloc_pkg::CNT_W-1:0] r_count, n_count;      // stacked slots
    logic                          r_out_valid, n_out_valid;
    ghalloc_pkg::t_out_beat        r_out, n_out;

    ghalloc_pkg::t_mem_req         mem_req;
    logic [ghalloc_pkg::GEN_W-1:0] gen_rdata;
    logic [ghalloc_pkg::IDX_W-1:0] stk_rdata;

    logic                          in_accept;
    logic                          out_free;
    logic                          in_range;
    logic                          stack_full;
    logic                          stack_empty;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign in_range    = r_req.slot_index < 32'(ghalloc_pkg::SLOTS);
    assign stack_full  = r_count >= ghalloc_pkg::CNT_W'(ghalloc_pkg::SLOTS);
    assign stack_empty = r_count == '0;

    ghalloc_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (mem_req),
        .o_gen_rdata (gen_rdata),
        .o_stk_rdata (stk_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (ghalloc_pkg::t_req'(i_in_beat.req_type) == ghalloc_pkg::REQ_ALLOC) begin
                        if (r_count == '0) begin
                            // empty stack, nothing to read
                            n_state = S_EXEC;
                        end else begin
                            mem_req.stk_re    = 1'b1;
                            mem_req.stk_raddr = ghalloc_pkg::IDX_W'(r_count - 1'b1);
                            n_state           = S_POP;
                        end
                    end else begin
                        mem_req.gen_re    = 1'b1;
                        mem_req.gen_raddr = i_in_beat.slot_index[ghalloc_pkg::IDX_W-1:0];
                        n_state           = S_EXEC;
                    end
                end
            end
            S_POP: begin
                // stack top is in, now fetch the slot's generation
                if (32'(stk_rdata) >= 32'(ghalloc_pkg::SLOTS)) begin
                    n_slot = '0;
                end else begin
                    n_slot = stk_rdata;
                end
                mem_req.gen_re    = 1'b1;
                mem_req.gen_raddr = n_slot;
                n_state           = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_state     = S_IDLE;
                    unique case (ghalloc_pkg::t_req'(r_req.req_type))
                        ghalloc_pkg::REQ_ALLOC: begin
                            if (stack_empty) begin
                                n_out.status = ghalloc_pkg::ST_EMPTY;
                            end else begin
                                n_out.status         = ghalloc_pkg::ST_OK;
                                n_out.out_index      = ghalloc_pkg::OUT_IDX_W'(r_slot);
                                n_out.out_generation = gen_rdata;
                                n_count              = r_count - 1'b1;
                            end
                        end
                        ghalloc_pkg::REQ_LOOKUP: begin
                            if (in_range && (gen_rdata == r_req.handle_generation)) begin
                                n_out.status         = ghalloc_pkg::ST_OK;
                                n_out.out_index      = r_req.slot_index[ghalloc_pkg::OUT_IDX_W-1:0];
                                n_out.out_generation = gen_rdata;
                            end else begin
                                n_out.status = ghalloc_pkg::ST_INVALID;
                            end
                        end
                        ghalloc_pkg::REQ_FREE: begin
                            if (in_range && !stack_full) begin
                                // bump generation, push slot
                                n_out.status      = ghalloc_pkg::ST_OK;
                                mem_req.gen_we    = 1'b1;
                                mem_req.gen_waddr = r_req.slot_index[ghalloc_pkg::IDX_W-1:0];
                                mem_req.gen_wdata = gen_rdata + 1'b1;
                                mem_req.stk_we    = 1'b1;
                                mem_req.stk_waddr = ghalloc_pkg::IDX_W'(r_count);
                                mem_req.stk_wdata = r_req.slot_index[ghalloc_pkg::IDX_W-1:0];
                                n_count           = r_count + 1'b1;
                            end else begin
                                n_out.status = ghalloc_pkg::ST_BAD_FREE;
                            end
                        end
                        ghalloc_pkg::REQ_NONE: begin
                            n_out.status = ghalloc_pkg::ST_BAD_FREE;
                        end
                        default: begin
                            n_out.status = ghalloc_pkg::ST_BAD_FREE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= ghalloc_pkg::CNT_W'(ghalloc_pkg::SLOTS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_beat;
        end
        r_slot <= n_slot;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule
